[src/ccrt_pkg.sv]
// shared types and constants of the camera command reply tracker
// no dependencies; used by every module

package ccrt_pkg;

	// item operation codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// start modes
	localparam logic [1:0] MODE_ACK        = 2'd0;
	localparam logic [1:0] MODE_COMPLETION = 2'd1;
	localparam logic [1:0] MODE_INQUIRY    = 2'd2;
	localparam logic [1:0] MODE_RESERVED   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_SYNTAX        = 3'd1;
	localparam logic [2:0] ST_BUFFER_FULL   = 3'd2;
	localparam logic [2:0] ST_CANCELLED     = 3'd3;
	localparam logic [2:0] ST_NO_SOCKETS    = 3'd4;
	localparam logic [2:0] ST_NOT_EXEC      = 3'd5;
	localparam logic [2:0] ST_TIMEOUT       = 3'd6;
	localparam logic [2:0] ST_BCAST_INQUIRY = 3'd7;

	// configuration register indexes
	localparam logic REG_ACK_TIMEOUT        = 1'b0;
	localparam logic REG_COMPLETION_TIMEOUT = 1'b1;

	localparam logic [15:0] ACK_TIMEOUT_RESET        = 16'd1000;
	localparam logic [15:0] COMPLETION_TIMEOUT_RESET = 16'd5000;

	// protocol bytes and nibbles
	localparam logic [3:0] ADDR_BROADCAST = 4'h8;
	localparam logic [7:0] BYTE_TERM      = 8'hff;
	localparam logic [7:0] BYTE_ERROR     = 8'h60;
	localparam logic [7:0] BYTE_INQ_ANS   = 8'h50;
	localparam logic [3:0] NIB_ACK        = 4'h4;
	localparam logic [3:0] NIB_COMPLETION = 4'h5;
	localparam logic [7:0] ERR_SYNTAX     = 8'h02;
	localparam logic [7:0] ERR_BUF_FULL   = 8'h03;
	localparam logic [7:0] ERR_CANCELLED  = 8'h04;
	localparam logic [7:0] ERR_NO_SOCKETS = 8'h05;
	localparam logic [7:0] ERR_NOT_EXEC   = 8'h41;

	// classified command kinds passed from front to back
	typedef enum logic [1:0] {
		KIND_START,
		KIND_BYTE,
		KIND_TICK
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] mode;
		logic [3:0] dest_address;
		logic       broadcast;
		logic [7:0] rx_byte;
		logic       term;
	} cmd_t;

endpackage

[src/ccrt_if.sv]
// channel interfaces: command items, results and configuration writes
// depends on nothing; the field widths are fixed here and match ccrt_pkg

interface ccrt_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [1:0] mode;
	logic [3:0] dest_address;
	logic [7:0] rx_byte;

	modport source(output valid, operation, mode, dest_address, rx_byte, input ready);
	modport sink(input valid, operation, mode, dest_address, rx_byte, output ready);
endinterface

interface ccrt_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] socket_number;
	logic [4:0] reply_length;

	modport source(output valid, status, socket_number, reply_length, input ready);
	modport sink(input valid, status, socket_number, reply_length, output ready);
endinterface

interface ccrt_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[src/camera_command_reply_tracker.sv]
// top level of the camera command reply tracker
// depends on ccrt_pkg, ccrt_if, ccrt_front, ccrt_back

// Follows one camera command transaction at a time. A start item names the
// camera address and the mode (acknowledge only, acknowledge then completion,
// inquiry); received bytes are gathered into reply frames ending at 0xff and
// judged against the transaction; tick items run the timeout. A result is
// given only when the transaction ends. Throughput is one item per clock
// while the back end does not stall: the front end classifies and queues an
// item in the cycle it is accepted, and the back end executes it from the
// two-entry queue and loads the result register.
// The back end stalls only while the result register holds a result that
// has not been taken; the queue lets the input keep flowing for up to two
// more items meanwhile. Configuration writes are taken every cycle and must
// only happen while no transaction is in flight.

module camera_command_reply_tracker #(
	parameter int MAX_FRAME = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	ccrt_item_if.sink     item,
	ccrt_cfg_if.sink      cfg,
	ccrt_result_if.source result
);

	// front to back queue head
	logic            q_valid;
	ccrt_pkg::cmd_t  q_head;
	logic            q_pop;

	// accept and classify, drops reserved operations and modes
	ccrt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	// transaction engine and result register
	ccrt_back #(
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.cfg        (cfg),
		.result     (result)
	);

	// an accepted tick always lands in the queue
	a_tick_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.operation == ccrt_pkg::OP_TICK) |=> q_valid)
		else $error("accepted tick missing from queue");

	// one-byte frames never end a transaction
	a_no_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.reply_length != 5'd1))
		else $error("result from one-byte frame");

	// timeouts and broadcast inquiries carry no frame
	a_no_len_on_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status == ccrt_pkg::ST_TIMEOUT
			|| result.status == ccrt_pkg::ST_BCAST_INQUIRY)) |-> (result.reply_length == 5'd0))
		else $error("frame length on timeout or broadcast");

	// no result is produced while the queue was empty the cycle before
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(q_valid))
		else $error("result without a queued item");

endmodule

[src/ccrt_front.sv]
// front end: accepts items, drops meaningless ones, classifies the rest
// and holds them in a two-entry queue; depends on ccrt_pkg, ccrt_if

module ccrt_front (
	input  logic              clk,
	input  logic              arst_n,
	ccrt_item_if.sink         item,
	output logic              head_valid,
	output ccrt_pkg::cmd_t    head,
	input  logic              pop
);

	logic [1:0]      fill_q;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	ccrt_pkg::cmd_t  slot_q [2];
	ccrt_pkg::cmd_t  cls;
	logic            keep;
	logic            push;
	logic            do_pop;

	assign item.ready = (fill_q != 2'd2);

	// classify
	always_comb begin
		cls.mode         = item.mode;
		cls.dest_address = item.dest_address;
		cls.broadcast    = (item.dest_address == ccrt_pkg::ADDR_BROADCAST);
		cls.rx_byte      = item.rx_byte;
		cls.term         = (item.rx_byte == ccrt_pkg::BYTE_TERM);
		keep             = 1'b1;
		unique case (item.operation)
			ccrt_pkg::OP_START: begin
				cls.kind = ccrt_pkg::KIND_START;
				keep     = (item.mode != ccrt_pkg::MODE_RESERVED);
			end
			ccrt_pkg::OP_BYTE: cls.kind = ccrt_pkg::KIND_BYTE;
			ccrt_pkg::OP_TICK: cls.kind = ccrt_pkg::KIND_TICK;
			default: begin
				cls.kind = ccrt_pkg::KIND_TICK;
				keep     = 1'b0;
			end
		endcase
	end

	assign push       = item.valid && item.ready && keep;
	assign head_valid = (fill_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !do_pop)
				fill_q <= fill_q + 2'd1;
			else if (do_pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= cls;
	end

endmodule

[src/ccrt_back.sv]
// back end: transaction state, frame gathering, reply judging, timeouts
// and the result register; depends on ccrt_pkg, ccrt_if

module ccrt_back #(
	parameter int MAX_FRAME = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ccrt_pkg::cmd_t    head,
	output logic              pop,
	ccrt_cfg_if.sink          cfg,
	ccrt_result_if.source     result
);

	localparam int CNT_W = $clog2(MAX_FRAME);

	localparam logic [1:0] PH_IDLE       = 2'd0;
	localparam logic [1:0] PH_ACK        = 2'd1;
	localparam logic [1:0] PH_COMPLETION = 2'd2;
	localparam logic [1:0] PH_INQUIRY    = 2'd3;

	logic [15:0]      ack_limit_q;
	logic [15:0]      comp_limit_q;
	logic [1:0]       phase_q;
	logic [1:0]       mode_q;
	logic [3:0]       target_q;
	logic [3:0]       socket_q;
	logic [7:0]       frame_head_q [4];
	logic [CNT_W-1:0] count_q;
	logic             overrun_q;
	logic [15:0]      elapsed_q;

	logic             out_valid_q;
	logic [2:0]       out_status_q;
	logic [3:0]       out_socket_q;
	logic [4:0]       out_len_q;

	logic             exec;
	logic             head_slot;
	logic [CNT_W:0]   len_wide;
	logic [4:0]       len;
	logic [7:0]       h1;
	logic             src_match;
	logic [2:0]       err_status;
	logic             err_hit;
	logic [15:0]      elapsed_inc;
	logic [15:0]      limit;

	// result
	logic             fin;
	logic [2:0]       fin_status;
	logic [3:0]       fin_socket;
	logic [4:0]       fin_len;
	logic             ack_capture;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_limit_q  <= ccrt_pkg::ACK_TIMEOUT_RESET;
			comp_limit_q <= ccrt_pkg::COMPLETION_TIMEOUT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ccrt_pkg::REG_ACK_TIMEOUT:        ack_limit_q  <= cfg.data;
				ccrt_pkg::REG_COMPLETION_TIMEOUT: comp_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign exec = head_valid && (!out_valid_q || result.ready);
	assign pop  = exec;

	assign head_slot = ({1'b0, count_q} < (CNT_W+1)'(4));
	assign len_wide  = {1'b0, count_q} + (CNT_W+1)'(1);
	assign len       = 5'(len_wide);
	// on a two-byte frame the second byte is the terminator arriving now
	assign h1        = (count_q == CNT_W'(1)) ? ccrt_pkg::BYTE_TERM : frame_head_q[1];
	assign src_match = !target_q[3] && (frame_head_q[0][7:4] == {1'b1, target_q[2:0]});

	always_comb begin
		unique case (frame_head_q[2])
			ccrt_pkg::ERR_SYNTAX:     err_status = ccrt_pkg::ST_SYNTAX;
			ccrt_pkg::ERR_BUF_FULL:   err_status = ccrt_pkg::ST_BUFFER_FULL;
			ccrt_pkg::ERR_CANCELLED:  err_status = ccrt_pkg::ST_CANCELLED;
			ccrt_pkg::ERR_NO_SOCKETS: err_status = ccrt_pkg::ST_NO_SOCKETS;
			ccrt_pkg::ERR_NOT_EXEC:   err_status = ccrt_pkg::ST_NOT_EXEC;
			default:                  err_status = ccrt_pkg::ST_OK;
		endcase
	end

	// a four-byte frame always ends in the terminator, so only the middle bytes matter
	assign err_hit = (len == 5'd4) && (h1 == ccrt_pkg::BYTE_ERROR)
		&& (err_status != ccrt_pkg::ST_OK);

	assign elapsed_inc = (elapsed_q == 16'hffff) ? elapsed_q : elapsed_q + 16'd1;
	assign limit       = (mode_q == ccrt_pkg::MODE_COMPLETION) ? comp_limit_q : ack_limit_q;

	// outcome of the item executing this cycle
	always_comb begin
		fin         = 1'b0;
		fin_status  = ccrt_pkg::ST_OK;
		fin_socket  = socket_q;
		fin_len     = 5'd0;
		ack_capture = 1'b0;
		if (exec) begin
			unique case (head.kind)
				ccrt_pkg::KIND_START: begin
					if (head.broadcast) begin
						fin        = 1'b1;
						fin_socket = 4'd0;
						fin_status = (head.mode == ccrt_pkg::MODE_INQUIRY)
							? ccrt_pkg::ST_BCAST_INQUIRY : ccrt_pkg::ST_OK;
					end
				end
				ccrt_pkg::KIND_BYTE: begin
					// overrun or lone terminator drops the frame
					if (phase_q != PH_IDLE && head.term && !overrun_q && (count_q != '0)
						&& src_match) begin
						priority if (err_hit) begin
							fin        = 1'b1;
							fin_status = err_status;
							fin_len    = len;
						end else if (phase_q == PH_ACK) begin
							if (len == 5'd3 && h1[7:4] == ccrt_pkg::NIB_ACK) begin
								if (mode_q == ccrt_pkg::MODE_COMPLETION) begin
									ack_capture = 1'b1;
								end else begin
									fin        = 1'b1;
									fin_socket = h1[3:0];
									fin_len    = len;
								end
							end
						end else if (phase_q == PH_COMPLETION) begin
							if (len == 5'd3 && h1 == {ccrt_pkg::NIB_COMPLETION, socket_q}) begin
								fin     = 1'b1;
								fin_len = len;
							end
						end else begin
							if (h1 == ccrt_pkg::BYTE_INQ_ANS) begin
								fin     = 1'b1;
								fin_len = len;
							end
						end
					end
				end
				ccrt_pkg::KIND_TICK: begin
					if (phase_q != PH_IDLE && elapsed_inc >= limit) begin
						fin        = 1'b1;
						fin_status = ccrt_pkg::ST_TIMEOUT;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			mode_q    <= ccrt_pkg::MODE_ACK;
			target_q  <= 4'd0;
			socket_q  <= 4'd0;
			count_q   <= '0;
			overrun_q <= 1'b0;
			elapsed_q <= 16'd0;
		end else if (exec) begin
			unique case (head.kind)
				ccrt_pkg::KIND_START: begin
					mode_q    <= head.mode;
					target_q  <= head.dest_address;
					socket_q  <= 4'd0;
					elapsed_q <= 16'd0;
					count_q   <= '0;
					overrun_q <= 1'b0;
					if (head.broadcast) begin
						phase_q <= PH_IDLE;
					end else begin
						phase_q <= (head.mode == ccrt_pkg::MODE_INQUIRY)
							? PH_INQUIRY : PH_ACK;
					end
				end
				ccrt_pkg::KIND_BYTE: begin
					if (phase_q != PH_IDLE) begin
						if (!head.term) begin
							if (count_q >= CNT_W'(MAX_FRAME - 1)) begin
								overrun_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end else begin
							count_q   <= '0;
							overrun_q <= 1'b0;
							if (fin) begin
								phase_q <= PH_IDLE;
							end else if (ack_capture) begin
								socket_q <= h1[3:0];
								phase_q  <= PH_COMPLETION;
							end
						end
					end
				end
				ccrt_pkg::KIND_TICK: begin
					if (phase_q != PH_IDLE) begin
						elapsed_q <= elapsed_inc;
						if (fin) begin
							phase_q   <= PH_IDLE;
							count_q   <= '0;
							overrun_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// first four bytes of the frame, terminator included
	always_ff @(posedge clk) begin
		if (exec && head.kind == ccrt_pkg::KIND_BYTE && phase_q != PH_IDLE && head_slot
			&& (head.term || count_q < CNT_W'(MAX_FRAME - 1)))
			frame_head_q[count_q[1:0]] <= head.rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec && fin) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && fin) begin
			out_status_q <= fin_status;
			out_socket_q <= fin_socket;
			out_len_q    <= fin_len;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.status        = out_status_q;
	assign result.socket_number = out_socket_q;
	assign result.reply_length  = out_len_q;

endmodule

[tb/tb.sv]
// self-checking testbench of the camera command reply tracker
// directed and random command, reply byte and tick items are checked against
// a transaction-level model kept here; depends on ccrt_pkg, interfaces, top level

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ccrt_pkg::*;

	localparam int MAX_FRAME     = 16;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int PHASES        = 8;

	// the operation code the block has to ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// where the tracker model stands in the transaction
	typedef enum logic [1:0] {
		TRK_IDLE,
		TRK_ACK,
		TRK_COMPLETION,
		TRK_INQUIRY
	} trk_phase_t;

	// what the driver does with the head of its queue
	typedef enum logic [1:0] {
		ENT_ITEM,
		ENT_CFG,
		ENT_SETTLE
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t kind;
		logic [1:0]  operation;
		logic [1:0]  mode;
		logic [3:0]  dest;
		logic [7:0]  rx;
		logic        cfg_index;
		logic [15:0] cfg_data;
		logic [3:0]  gap;
	} entry_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] socket_number;
		logic [4:0] reply_length;
	} reply_t;

	logic clk;
	logic arst_n;

	ccrt_item_if   item_ch();
	ccrt_cfg_if    cfg_ch();
	ccrt_result_if result_ch();

	camera_command_reply_tracker #(
		.MAX_FRAME(MAX_FRAME)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.cfg   (cfg_ch),
		.result(result_ch)
	);

	// stimulus waiting for the driver, and the replies the model says must come
	entry_t stim_q[$];
	reply_t replies_due[$];

	// tracker model state
	trk_phase_t  trk_phase;
	logic [1:0]  trk_mode;
	logic [3:0]  trk_addr;
	logic [3:0]  trk_socket;
	logic [7:0]  trk_head[4];
	logic [4:0]  trk_count;
	logic        trk_over;
	logic [15:0] trk_ticks;
	logic [15:0] lim_ack;
	logic [15:0] lim_completion;

	// generator side: limits in force and whether gaps are suppressed
	int gen_ack_lim;
	int gen_cmp_lim;
	bit gen_calm;
	int gen_items;

	// driver state
	entry_t cur;
	bit     entry_loaded;
	bit     item_busy;
	bit     cfg_busy;
	bit     item_took;
	bit     cfg_took;
	int     hold_left;
	int     settle_run;

	// monitor state
	reply_t got;
	reply_t want;
	bit     reply_took;
	bit     stall_drawn;
	bit     calm_sink;
	int     stall_left;

	int cycle_count;
	int mismatches;
	int items_taken;
	int replies_checked;
	int cfg_writes;

	// ---------------------------------------------------------------
	// tracker model: one call per accepted item transaction
	// ---------------------------------------------------------------
	task automatic track_item(input logic [1:0] op, input logic [1:0] mode,
			input logic [3:0] dest, input logic [7:0] rx);
		reply_t      outcome;
		logic        ended;
		logic [4:0]  len;
		logic [2:0]  err;
		logic [15:0] limit;
		begin
			ended = 1'b0;
			outcome = '0;
			case (op)
				OP_START: begin
					// reserved mode leaves everything as it was
					if (mode != MODE_RESERVED) begin
						trk_mode = mode;
						trk_addr = dest;
						trk_socket = '0;
						trk_ticks = '0;
						trk_count = '0;
						trk_over = 1'b0;
						if (dest == ADDR_BROADCAST) begin
							// broadcast ends at once, inquiry is refused
							if (mode == MODE_INQUIRY) begin
								outcome.status = ST_BCAST_INQUIRY;
							end else begin
								outcome.status = ST_OK;
							end
							ended = 1'b1;
						end else if (mode == MODE_INQUIRY) begin
							trk_phase = TRK_INQUIRY;
						end else begin
							trk_phase = TRK_ACK;
						end
					end
				end
				OP_BYTE: begin
					if (trk_phase != TRK_IDLE) begin
						if (rx != BYTE_TERM) begin
							// past the frame limit only the overrun mark is kept
							if (trk_count >= MAX_FRAME - 1) begin
								trk_over = 1'b1;
							end else begin
								if (trk_count < 4) begin
									trk_head[trk_count[1:0]] = rx;
								end
								trk_count = trk_count + 5'd1;
							end
						end else begin
							if (trk_count < 4) begin
								trk_head[trk_count[1:0]] = BYTE_TERM;
							end
							len = trk_count + 5'd1;
							// overrun and one-byte frames are dropped, source must match
							if (!trk_over && len >= 5'd2 && trk_addr < ADDR_BROADCAST
									&& trk_head[0][7:4] == {1'b1, trk_addr[2:0]}) begin
								err = ST_OK;
								if (len == 5'd4 && trk_head[1] == BYTE_ERROR
										&& trk_head[3] == BYTE_TERM) begin
									case (trk_head[2])
										ERR_SYNTAX:     err = ST_SYNTAX;
										ERR_BUF_FULL:   err = ST_BUFFER_FULL;
										ERR_CANCELLED:  err = ST_CANCELLED;
										ERR_NO_SOCKETS: err = ST_NO_SOCKETS;
										ERR_NOT_EXEC:   err = ST_NOT_EXEC;
										default:        err = ST_OK;
									endcase
								end
								if (err != ST_OK) begin
									outcome.status = err;
									outcome.socket_number = trk_socket;
									outcome.reply_length = len;
									ended = 1'b1;
								end else begin
									case (trk_phase)
										TRK_ACK: begin
											if (len == 5'd3 && trk_head[1][7:4] == NIB_ACK) begin
												if (trk_mode == MODE_COMPLETION) begin
													// hold the socket and wait for completion
													trk_socket = trk_head[1][3:0];
													trk_phase = TRK_COMPLETION;
												end else begin
													outcome.status = ST_OK;
													outcome.socket_number = trk_head[1][3:0];
													outcome.reply_length = len;
													ended = 1'b1;
												end
											end
										end
										TRK_COMPLETION: begin
											if (len == 5'd3
													&& trk_head[1] == {NIB_COMPLETION, trk_socket}) begin
												outcome.status = ST_OK;
												outcome.socket_number = trk_socket;
												outcome.reply_length = len;
												ended = 1'b1;
											end
										end
										TRK_INQUIRY: begin
											if (trk_head[1] == BYTE_INQ_ANS) begin
												outcome.status = ST_OK;
												outcome.socket_number = trk_socket;
												outcome.reply_length = len;
												ended = 1'b1;
											end
										end
										default: begin
										end
									endcase
								end
							end
							trk_count = '0;
							trk_over = 1'b0;
						end
					end
				end
				OP_TICK: begin
					if (trk_phase != TRK_IDLE) begin
						if (trk_ticks != 16'hffff) begin
							trk_ticks = trk_ticks + 16'd1;
						end
						if (trk_mode == MODE_COMPLETION) begin
							limit = lim_completion;
						end else begin
							limit = lim_ack;
						end
						if (trk_ticks >= limit) begin
							outcome.status = ST_TIMEOUT;
							outcome.socket_number = trk_socket;
							ended = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			if (ended) begin
				replies_due.push_back(outcome);
				trk_phase = TRK_IDLE;
				trk_count = '0;
				trk_over = 1'b0;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// stimulus building blocks
	// ---------------------------------------------------------------
	task automatic push_item(input logic [1:0] op, input logic [1:0] mode,
			input logic [3:0] dest, input logic [7:0] rx);
		entry_t e;
		begin
			e = '0;
			e.kind = ENT_ITEM;
			e.operation = op;
			e.mode = mode;
			e.dest = dest;
			e.rx = rx;
			e.gap = gen_calm ? 4'd0 : 4'($urandom_range(0, 10));
			stim_q.push_back(e);
			if (op != OP_UNUSED && !(op == OP_START && mode == MODE_RESERVED)) begin
				gen_items++;
			end
		end
	endtask

	// reply byte with random don't-care fields
	task automatic push_byte(input logic [7:0] b);
		begin
			push_item(OP_BYTE, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), b);
		end
	endtask

	task automatic push_start(input logic [1:0] mode, input logic [3:0] dest);
		begin
			push_item(OP_START, mode, dest, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic push_ticks(input int n);
		begin
			repeat (n) begin
				push_item(OP_TICK, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
					8'($urandom_range(0, 255)));
			end
		end
	endtask

	// three-byte frame: acknowledge, completion or something shaped like them
	task automatic push_short_frame(input logic [7:0] h0, input logic [7:0] h1);
		begin
			push_byte(h0);
			push_byte(h1);
			push_byte(BYTE_TERM);
		end
	endtask

	// make the driver wait until the block has nothing left to say
	task automatic push_settle();
		entry_t e;
		begin
			e = '0;
			e.kind = ENT_SETTLE;
			stim_q.push_back(e);
		end
	endtask

	task automatic push_cfg(input logic idx, input logic [15:0] data);
		entry_t e;
		begin
			e = '0;
			e.kind = ENT_CFG;
			e.cfg_index = idx;
			e.cfg_data = data;
			e.gap = 4'($urandom_range(0, 10));
			stim_q.push_back(e);
		end
	endtask

	function automatic logic [7:0] frame_lead(input logic [3:0] src);
		logic [3:0] lo;
		begin
			lo = 4'($urandom_range(0, 15));
			return {src, lo};
		end
	endfunction

	// any byte but the frame terminator
	function automatic logic [7:0] data_byte();
		begin
			return 8'($urandom_range(0, 254));
		end
	endfunction

	// close any open transaction, let the block go quiet, then load new limits
	task automatic queue_setting(input int ack, input int cmp);
		begin
			push_start(2'($urandom_range(0, 2)), ADDR_BROADCAST);
			push_settle();
			if ($urandom_range(0, 1) == 0) begin
				push_cfg(REG_ACK_TIMEOUT, 16'(ack));
				push_cfg(REG_COMPLETION_TIMEOUT, 16'(cmp));
			end else begin
				push_cfg(REG_COMPLETION_TIMEOUT, 16'(cmp));
				push_cfg(REG_ACK_TIMEOUT, 16'(ack));
			end
			gen_ack_lim = ack;
			gen_cmp_lim = cmp;
		end
	endtask

	// one command with a few reply events, mostly well formed
	task automatic queue_exchange();
		logic [1:0] mode;
		logic [3:0] dest;
		logic [3:0] src;
		logic [3:0] sock;
		logic [3:0] csock;
		logic [3:0] other;
		logic [7:0] code;
		int pick;
		int lim;
		int n;
		begin
			mode = 2'($urandom_range(0, 2));
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				dest = 4'($urandom_range(0, 7));
			end else if (pick < 88) begin
				dest = ADDR_BROADCAST;
			end else begin
				dest = 4'($urandom_range(9, 15));
			end
			src = dest + 4'd8;
			sock = 4'($urandom_range(0, 15));
			lim = (mode == MODE_COMPLETION) ? gen_cmp_lim : gen_ack_lim;
			gen_calm = ($urandom_range(0, 4) == 0);
			push_start(mode, dest);
			repeat ($urandom_range(1, 4)) begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					// the reply the mode waits for
					if (mode == MODE_INQUIRY) begin
						push_byte(frame_lead(src));
						push_byte(BYTE_INQ_ANS);
						repeat ($urandom_range(0, 12)) push_byte(data_byte());
						push_byte(BYTE_TERM);
					end else begin
						push_short_frame(frame_lead(src), {NIB_ACK, sock});
						if (mode == MODE_COMPLETION) begin
							if ($urandom_range(0, 2) == 0) begin
								push_ticks($urandom_range(1, 3));
							end
							csock = sock;
							if ($urandom_range(0, 5) == 0) begin
								other = 4'($urandom_range(1, 15));
								csock = sock ^ other;
							end
							push_short_frame(frame_lead(src), {NIB_COMPLETION, csock});
						end
					end
				end else if (pick < 52) begin
					// error frame, now and then with an unknown code
					case ($urandom_range(0, 5))
						0:       code = ERR_SYNTAX;
						1:       code = ERR_BUF_FULL;
						2:       code = ERR_CANCELLED;
						3:       code = ERR_NO_SOCKETS;
						4:       code = ERR_NOT_EXEC;
						default: code = data_byte();
					endcase
					push_byte(frame_lead(src));
					push_byte(BYTE_ERROR);
					push_byte(code);
					push_byte(BYTE_TERM);
				end else if (pick < 67) begin
					// tick burst, often exactly up to a small limit
					if (lim <= 24 && $urandom_range(0, 1) == 0) begin
						n = lim;
					end else begin
						n = $urandom_range(1, (lim < 24) ? lim + 1 : 24);
					end
					push_ticks(n);
				end else if (pick < 75) begin
					// line noise closed by a terminator
					repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)));
					push_byte(BYTE_TERM);
				end else if (pick < 82) begin
					// some other camera answering
					other = 4'($urandom_range(1, 15));
					push_short_frame(frame_lead(src ^ other), 8'($urandom_range(0, 255)));
				end else if (pick < 87) begin
					// inquiry answer right at or past the frame limit
					push_byte(frame_lead(src));
					push_byte(BYTE_INQ_ANS);
					repeat ($urandom_range(MAX_FRAME - 3, MAX_FRAME + 1)) push_byte(data_byte());
					push_byte(BYTE_TERM);
				end else if (pick < 90) begin
					push_byte(BYTE_TERM);
				end else if (pick < 93) begin
					push_byte(8'($urandom_range(0, 255)));
				end else if (pick < 95) begin
					// items the block has to ignore
					if ($urandom_range(0, 1) == 0) begin
						push_item(OP_UNUSED, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
							8'($urandom_range(0, 255)));
					end else begin
						push_start(MODE_RESERVED, 4'($urandom_range(0, 15)));
					end
				end else if (pick < 97) begin
					// sender holds off until every result is in
					push_settle();
				end else begin
					// acknowledge one byte too long
					push_byte(frame_lead(src));
					push_byte({NIB_ACK, sock});
					push_byte(data_byte());
					push_byte(BYTE_TERM);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// clock and cycle budget
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
		$display("tb: FAIL");
		$finish;
	end

	// ---------------------------------------------------------------
	// handshake sampling at the rising edge: model and config mirror
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				track_item(item_ch.operation, item_ch.mode, item_ch.dest_address,
					item_ch.rx_byte);
				items_taken++;
				item_took = 1'b1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == REG_ACK_TIMEOUT) begin
					lim_ack = cfg_ch.data;
				end else begin
					lim_completion = cfg_ch.data;
				end
				cfg_writes++;
				cfg_took = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// driver: works through the stimulus queue at the falling edge
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			// a transaction taken at the last rising edge frees the channel
			if (item_took) begin
				item_took = 1'b0;
				item_busy = 1'b0;
			end
			if (cfg_took) begin
				cfg_took = 1'b0;
				cfg_busy = 1'b0;
			end
			if (!item_busy && !cfg_busy) begin
				if (!entry_loaded && stim_q.size() > 0) begin
					cur = stim_q.pop_front();
					entry_loaded = 1'b1;
					hold_left = int'(cur.gap);
					settle_run = 0;
				end
				if (entry_loaded) begin
					if (hold_left > 0) begin
						hold_left--;
					end else begin
						case (cur.kind)
							ENT_ITEM: begin
								item_ch.operation <= cur.operation;
								item_ch.mode <= cur.mode;
								item_ch.dest_address <= cur.dest;
								item_ch.rx_byte <= cur.rx;
								item_busy = 1'b1;
								entry_loaded = 1'b0;
							end
							ENT_CFG: begin
								cfg_ch.index <= cur.cfg_index;
								cfg_ch.data <= cur.cfg_data;
								cfg_busy = 1'b1;
								entry_loaded = 1'b0;
							end
							default: begin
								// hold until the block has gone quiet past the last result
								if (replies_due.size() == 0) begin
									settle_run++;
								end else begin
									settle_run = 0;
								end
								if (settle_run >= SETTLE_CYCLES) begin
									entry_loaded = 1'b0;
								end
							end
						endcase
					end
				end
			end
			// one assignment per step keeps back-to-back valid steady
			item_ch.valid <= item_busy;
			cfg_ch.valid <= cfg_busy;
		end
	end

	// ---------------------------------------------------------------
	// monitor: checks each result transaction against the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.status = result_ch.status;
				got.socket_number = result_ch.socket_number;
				got.reply_length = result_ch.reply_length;
				if (replies_due.size() == 0) begin
					$display("%0t: expected no result, got status %0d socket %0d length %0d",
						$time, got.status, got.socket_number, got.reply_length);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (got !== want) begin
						$display({"%0t: expected status %0d socket %0d length %0d,",
							" got status %0d socket %0d length %0d"},
							$time, want.status, want.socket_number, want.reply_length,
							got.status, got.socket_number, got.reply_length);
						mismatches++;
					end
				end
				replies_checked++;
				reply_took = 1'b1;
			end
		end
	end

	// result back-pressure: a fresh stall for every result, with calm stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (reply_took) begin
				reply_took = 1'b0;
				stall_drawn = 1'b0;
				if ($urandom_range(0, 15) == 0) begin
					calm_sink = !calm_sink;
				end
			end
			if (result_ch.valid && !stall_drawn) begin
				stall_left = calm_sink ? 0 : $urandom_range(0, 10);
				stall_drawn = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int k;
		int phase_end;

		// every block input known from time zero
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = OP_START;
		item_ch.mode = MODE_ACK;
		item_ch.dest_address = '0;
		item_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_ACK_TIMEOUT;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;

		cycle_count = 0;
		mismatches = 0;
		items_taken = 0;
		replies_checked = 0;
		cfg_writes = 0;
		gen_items = 0;
		gen_calm = 1'b0;
		calm_sink = 1'b0;

		// model after reset
		trk_phase = TRK_IDLE;
		trk_mode = MODE_ACK;
		trk_addr = '0;
		trk_socket = '0;
		trk_count = '0;
		trk_over = 1'b0;
		trk_ticks = '0;
		lim_ack = ACK_TIMEOUT_RESET;
		lim_completion = COMPLETION_TIMEOUT_RESET;
		gen_ack_lim = ACK_TIMEOUT_RESET;
		gen_cmp_lim = COMPLETION_TIMEOUT_RESET;

		// directed: ignored items while idle
		push_item(OP_UNUSED, MODE_RESERVED, 4'hf, 8'hff);
		push_byte(8'h00);
		push_ticks(1);
		push_start(MODE_RESERVED, 4'h1);
		// broadcast in all three modes
		push_start(MODE_ACK, ADDR_BROADCAST);
		push_start(MODE_INQUIRY, ADDR_BROADCAST);
		push_start(MODE_COMPLETION, ADDR_BROADCAST);
		// acknowledge only from camera 0
		push_start(MODE_ACK, 4'h0);
		push_short_frame(8'h80, {NIB_ACK, 4'h0});
		// acknowledge then completion from camera 7 on socket 15
		push_start(MODE_COMPLETION, 4'h7);
		push_short_frame(8'hf3, {NIB_ACK, 4'hf});
		push_short_frame(8'hf0, {NIB_COMPLETION, 4'hf});
		// an address no camera answers, dropped by a new start
		push_start(MODE_INQUIRY, 4'hf);
		push_start(MODE_INQUIRY, 4'h3);
		// not-executable error ends the inquiry
		push_byte(8'hb0);
		push_byte(BYTE_ERROR);
		push_byte(ERR_NOT_EXEC);
		push_byte(BYTE_TERM);

		// random phases, each under its own pair of limits
		for (k = 0; k < PHASES; k++) begin
			case (k)
				0:       begin end                 // reset limits
				1:       queue_setting(1, 1);
				2:       queue_setting(65535, 65535);
				3:       queue_setting(4, 12);
				4:       queue_setting(2, 65535);
				5:       queue_setting(65535, 3);
				6:       queue_setting($urandom_range(1, 20), $urandom_range(1, 40));
				default: queue_setting(ACK_TIMEOUT_RESET, COMPLETION_TIMEOUT_RESET);
			endcase
			phase_end = gen_items + RANDOM_ITEMS / PHASES;
			while (gen_items < phase_end) queue_exchange();
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all stimulus taken and every predicted result in
		while (stim_q.size() > 0 || entry_loaded || item_busy || cfg_busy
				|| replies_due.size() > 0) begin
			@(posedge clk);
		end
		repeat (4 * SETTLE_CYCLES) @(posedge clk);

		$display("summary: %0d items and %0d register writes sent, %0d results checked",
			items_taken, cfg_writes, replies_checked);
		$display("summary: %0d mismatches over %0d limit settings", mismatches, PHASES);
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
